// ----- sv/led_pkg.sv -----
`default_nettype none
package led_pkg;

  localparam int DEFAULT_DEPTH = 32;
  localparam logic [5:0] CAPACITY_RESET = 6'd32;

  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_EOL   = 2'd2;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic [7:0] CHAR_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } led_cmd_t;

endpackage
`default_nettype wire

// ----- sv/line_editor_with_echo_core.sv -----
`default_nettype none
// Channel   Handshake               Word
// rx        in_valid / in_ready     rx_byte
// result    out_valid / out_ready   item_kind, data_byte, line_length, last_of_run
// config    cfg_valid / cfg_ready   cfg_data (line capacity)
//
// The first result of a byte is registered after the byte leaves the queue for the back end.
// The back end then emits one echo word for a stored character, backspace, space and
// backspace for an erase, and CR, LF, the line bytes and an end word for a line end,
// where each line byte waits for the registered read of the line buffer.
// Reset empties the line and the command queue and sets the capacity to 32;
// the line buffer itself is not cleared. Up to two bytes wait in the queue while
// the back end is busy or the result register is stalled.
module line_editor_with_echo_core #(
  parameter int BUFFER_DEPTH = led_pkg::DEFAULT_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      item_kind,
  output logic [7:0]      data_byte,
  output logic [4:0]      line_length,
  output logic            last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [5:0] cfg_data
);
  import led_pkg::*;

  logic       line_capacity_q;
  logic [5:0] line_capacity;
  led_cmd_t   push_cmd;
  led_cmd_t   head;
  logic       push;
  logic       space;
  logic       avail;
  logic       pop;

  assign cfg_ready = 1'b1;
  assign line_capacity_q = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_capacity <= CAPACITY_RESET;
    end else if (line_capacity_q) begin
      line_capacity <= cfg_data;
    end
  end

  led_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .queue_space (space),
    .push        (push),
    .cmd         (push_cmd)
  );

  led_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .space    (space),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  led_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_avail     (avail),
    .cmd           (head),
    .cmd_pop       (pop),
    .line_capacity (line_capacity),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .item_kind     (item_kind),
    .data_byte     (data_byte),
    .line_length   (line_length),
    .last_of_run   (last_of_run)
  );

endmodule
`default_nettype wire

// ----- sv/led_front.sv -----
`default_nettype none
module led_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        rx_byte,
  input  wire logic              queue_space,
  output logic                   push,
  output led_pkg::led_cmd_t      cmd
);
  import led_pkg::*;

  assign in_ready = queue_space;
  assign push     = in_valid && queue_space;

  always_comb begin
    cmd.data = rx_byte;
    unique case (rx_byte)
      CHAR_DEL, CHAR_BS: cmd.op = OP_ERASE;
      CHAR_CR, CHAR_LF:  cmd.op = OP_EOL;
      default:           cmd.op = OP_CHAR;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/led_queue.sv -----
`default_nettype none
module led_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire led_pkg::led_cmd_t push_cmd,
  output logic                   space,
  input  wire logic              pop,
  output logic                   avail,
  output led_pkg::led_cmd_t      head
);
  import led_pkg::*;

  led_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign space = (fill != 2'd2);
  assign avail = (fill != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/led_back.sv -----
`default_nettype none
module led_back #(
  parameter int BUFFER_DEPTH = led_pkg::DEFAULT_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_avail,
  input  wire led_pkg::led_cmd_t cmd,
  output logic                   cmd_pop,
  input  wire logic [5:0]        line_capacity,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             item_kind,
  output logic [7:0]             data_byte,
  output logic [4:0]             line_length,
  output logic                   last_of_run
);
  import led_pkg::*;

  localparam int CW = $clog2(BUFFER_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPACE = 3'd1;
  localparam logic [2:0] S_BS    = 3'd2;
  localparam logic [2:0] S_LF    = 3'd3;
  localparam logic [2:0] S_LINE  = 3'd4;
  localparam logic [2:0] S_END   = 3'd5;

  logic [7:0]    line_store [BUFFER_DEPTH];
  logic [7:0]    rd_data;
  logic [CW-1:0] char_count;
  logic [CW-1:0] idx;
  logic [CW-1:0] len;
  logic          rd_ok;
  logic [2:0]    state;
  logic [6:0]    cap;
  logic [6:0]    max_chars;
  logic          out_free;
  logic          wr_en;
  logic          emit;

  always_comb begin
    cap = {1'b0, line_capacity};
    if (cap > 7'(BUFFER_DEPTH)) begin
      cap = 7'(BUFFER_DEPTH);
    end
    if (cap == 7'd0) begin
      cap = 7'd1;
    end
    max_chars = cap - 7'd1;
  end

  assign out_free = !out_valid || out_ready;
  assign cmd_pop  = (state == S_IDLE) && cmd_avail && out_free;
  assign wr_en    = cmd_pop && (cmd.op == OP_CHAR) && (7'(char_count) < max_chars);

  // A new word enters the result register in this cycle.
  assign emit = (cmd_pop && ((cmd.op == OP_ERASE) ? (char_count != '0) :
                             (cmd.op == OP_EOL) ? 1'b1 : wr_en)) ||
                (out_free && ((state == S_SPACE) || (state == S_BS) || (state == S_LF) ||
                              (state == S_END) || ((state == S_LINE) && rd_ok)));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[char_count] <= cmd.data;
    end
    rd_data <= line_store[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_count <= '0;
      out_valid  <= 1'b0;
      rd_ok      <= 1'b0;
      idx        <= '0;
      len        <= '0;
    end else begin
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            unique case (cmd.op)
              OP_ERASE: begin
                if (char_count != '0) begin
                  char_count  <= char_count - CW'(1);
                  item_kind   <= KIND_ECHO;
                  data_byte   <= CHAR_BS;
                  line_length <= 5'd0;
                  last_of_run <= 1'b0;
                  state       <= S_SPACE;
                end
              end
              OP_EOL: begin
                item_kind   <= KIND_ECHO;
                data_byte   <= CHAR_CR;
                line_length <= 5'd0;
                last_of_run <= 1'b0;
                idx         <= '0;
                rd_ok       <= 1'b0;
                state       <= S_LF;
              end
              default: begin
                if (wr_en) begin
                  char_count  <= char_count + CW'(1);
                  item_kind   <= KIND_ECHO;
                  data_byte   <= cmd.data;
                  line_length <= 5'd0;
                  last_of_run <= 1'b1;
                end
              end
            endcase
          end
        end
        S_SPACE: begin
          if (out_free) begin
            data_byte   <= CHAR_SPACE;
            last_of_run <= 1'b0;
            state       <= S_BS;
          end
        end
        S_BS: begin
          if (out_free) begin
            data_byte   <= CHAR_BS;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_LF: begin
          rd_ok <= 1'b1;
          if (out_free) begin
            item_kind   <= KIND_ECHO;
            data_byte   <= CHAR_LF;
            last_of_run <= 1'b0;
            len         <= char_count;
            char_count  <= '0;
            state       <= (char_count == '0) ? S_END : S_LINE;
          end
        end
        S_LINE: begin
          if (out_free && rd_ok) begin
            item_kind   <= KIND_LINE;
            data_byte   <= rd_data;
            line_length <= 5'd0;
            last_of_run <= 1'b0;
            rd_ok       <= 1'b0;
            if (7'(idx) + 7'd1 == 7'(len)) begin
              state <= S_END;
            end else begin
              idx <= idx + CW'(1);
            end
          end else begin
            rd_ok <= 1'b1;
          end
        end
        S_END: begin
          if (out_free) begin
            item_kind   <= KIND_END;
            data_byte   <= 8'd0;
            line_length <= 5'(len);
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
